### hdl/psst_pkg.sv
// Shared types and constants of the positional sequence store.
`timescale 1ns / 1ps

package psst_pkg;

    parameter int unsigned PSST_CAPACITY = 16;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_POS,
        FN_INS_HEAD,
        FN_INS_TAIL,
        FN_DEL_POS,
        FN_DEL_HEAD,
        FN_DEL_TAIL,
        FN_RD_FWD,
        FN_RD_REV
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_INDEX,
        ST_EMPTY,
        ST_FULL
    } t_status;

    // What one cell of the chain takes in at the next edge.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FROM_PREV,
        OP_FROM_NEXT
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

### hdl/psst_if.sv
// Command and result channel interfaces of the positional sequence store.
`timescale 1ns / 1ps

interface psst_in_if;
    import psst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output pos, output value, input ready);
    modport sink   (input valid, input func, input pos, input value, output ready);
endinterface

interface psst_out_if;
    import psst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output data_out, output status, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input data_out, input status, input last,
                    input occupancy, output ready);
endinterface

### hdl/psst_cell.sv
// One storage cell of the entry chain, loading, holding or taking a neighbor's entry.
`timescale 1ns / 1ps

module psst_cell (
    input  logic                        i_clk,
    input  psst_pkg::t_cell_op          i_op,
    input  logic [psst_pkg::DATA_W-1:0] i_load,
    input  logic [psst_pkg::DATA_W-1:0] i_prev,
    input  logic [psst_pkg::DATA_W-1:0] i_next,
    output logic [psst_pkg::DATA_W-1:0] o_value
);
    import psst_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        unique case (i_op)
            OP_LOAD:      n_value = i_load;
            OP_FROM_PREV: n_value = i_prev;
            OP_FROM_NEXT: n_value = i_next;
            default:      n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hdl/positional_sequence_store.sv
// Top level of the positional sequence store: command decode, read sequencer and cell chain.
`timescale 1ns / 1ps

// Holds up to CAPACITY signed words in a chain of cells, head in cell 0. An insert,
// delete or a read of an empty store gives one status word; the command port stays
// ready as long as the result register is free or being drained. A read of N
// entries gives N result words, one per cycle while the result register is free or
// being drained, because the chain rotates by one cell per word to bring each entry
// to the output; the rotation ends with the chain in its original order. No command
// is taken while a read is in progress. Entry contents are undefined after reset and
// never show, since only entries below the occupancy are read.
module positional_sequence_store #(
    parameter int unsigned CAPACITY = psst_pkg::PSST_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psst_in_if.sink          i_cmd,
    psst_out_if.source       o_res
);
    import psst_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_k;
    logic [CW-1:0]     n_k;
    logic              r_fwd;
    logic              n_fwd;

    logic              r_ov;
    logic [DATA_W-1:0] r_data;
    t_status           r_status;
    logic              r_last;
    logic [OCC_W-1:0]  r_occ;

    logic              out_free;
    logic              cmd_fire;
    logic              step;
    logic              last_k;
    t_func             cmd_func;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     cntm1_w;
    logic [CW-1:0]     tail_cnt;
    logic              is_empty;
    logic              is_full;

    logic              do_ins;
    logic              do_del;
    logic              do_read;
    logic [PW-1:0]     act_pos;
    t_status           cmd_status;

    logic              load_out;
    logic [DATA_W-1:0] out_data;
    t_status           out_status;
    logic              out_last;
    logic [CW-1:0]     out_count;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    t_cell_op          cell_op  [CAPACITY];
    logic [DATA_W-1:0] load_data;
    logic [DATA_W-1:0] tail_val;

    assign out_free = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign step = (r_state == S_READ) && out_free;
    assign cmd_func = t_func'(i_cmd.func);

    assign pos_w    = PW'(i_cmd.pos);
    assign cnt_w    = PW'(r_count);
    assign cntm1_w  = cnt_w - PW'(1);
    assign tail_cnt = r_count - CW'(1);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= CW'(CAPACITY));
    assign last_k   = (r_k == tail_cnt);

    // The tail is the only entry read at a moving place.
    assign tail_val = cell_val[tail_cnt[IW-1:0]];

    // Command decode.
    always_comb begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_read    = 1'b0;
        act_pos    = '0;
        cmd_status = ST_OK;
        unique case (cmd_func)
            FN_INS_POS: begin
                act_pos = pos_w;
                if (pos_w > cnt_w) begin
                    cmd_status = ST_INDEX;
                end else if (is_full) begin
                    cmd_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            FN_INS_HEAD, FN_INS_TAIL: begin
                act_pos = (cmd_func == FN_INS_TAIL) ? cnt_w : '0;
                if (is_full) begin
                    cmd_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            FN_DEL_POS: begin
                act_pos = pos_w;
                if (is_empty) begin
                    cmd_status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    cmd_status = ST_INDEX;
                end else begin
                    do_del = 1'b1;
                end
            end
            FN_DEL_HEAD, FN_DEL_TAIL: begin
                act_pos = (cmd_func == FN_DEL_TAIL) ? cntm1_w : '0;
                if (is_empty) begin
                    cmd_status = ST_EMPTY;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
                if (is_empty) begin
                    cmd_status = ST_EMPTY;
                end else begin
                    do_read = 1'b1;
                end
            end
        endcase
    end

    // Next state of the read sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire && do_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (step && last_k) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: counters and the result word.
    always_comb begin
        n_count    = r_count;
        n_k        = r_k;
        n_fwd      = r_fwd;
        load_out   = 1'b0;
        out_data   = '0;
        out_status = ST_OK;
        out_last   = 1'b1;
        out_count  = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    if (do_read) begin
                        n_k   = '0;
                        n_fwd = (cmd_func == FN_RD_FWD);
                    end else begin
                        if (do_ins) begin
                            n_count = r_count + CW'(1);
                        end else if (do_del) begin
                            n_count = r_count - CW'(1);
                        end
                        load_out   = 1'b1;
                        out_status = cmd_status;
                        out_count  = n_count;
                    end
                end
            end
            S_READ: begin
                if (step) begin
                    load_out = 1'b1;
                    out_data = r_fwd ? cell_val[0] : tail_val;
                    out_last = last_k;
                    n_k      = r_k + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_fwd   <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_fwd   <= n_fwd;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_data   <= out_data;
            r_status <= out_status;
            r_last   <= out_last;
            r_occ    <= OCC_W'(out_count);
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.data_out  = r_data;
    assign o_res.status    = r_status;
    assign o_res.last      = r_last;
    assign o_res.occupancy = r_occ;

    // A forward read rotates the occupied part of the chain toward the head, the
    // old head wrapping into the tail; a reverse read rotates the other way.
    always_comb begin
        if (cmd_fire && do_ins) begin
            load_data = i_cmd.value;
        end else if (r_fwd) begin
            load_data = cell_val[0];
        end else begin
            load_data = tail_val;
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [PW-1:0] CELL_IDX = PW'(gi);
        logic [DATA_W-1:0] prev_val;
        logic [DATA_W-1:0] next_val;

        if (gi == 0) begin : g_head
            assign prev_val = cell_val[gi];
        end else begin : g_prev
            assign prev_val = cell_val[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_end
            assign next_val = cell_val[gi];
        end else begin : g_next
            assign next_val = cell_val[gi+1];
        end

        always_comb begin
            cell_op[gi] = OP_HOLD;
            priority if (cmd_fire && do_ins) begin
                if (CELL_IDX == act_pos) begin
                    cell_op[gi] = OP_LOAD;
                end else if (CELL_IDX > act_pos) begin
                    cell_op[gi] = OP_FROM_PREV;
                end
            end else if (cmd_fire && do_del) begin
                if (CELL_IDX >= act_pos) begin
                    cell_op[gi] = OP_FROM_NEXT;
                end
            end else if (step && r_fwd) begin
                if (CELL_IDX == cntm1_w) begin
                    cell_op[gi] = OP_LOAD;
                end else if (CELL_IDX < cntm1_w) begin
                    cell_op[gi] = OP_FROM_NEXT;
                end
            end else if (step) begin
                if (CELL_IDX == '0) begin
                    cell_op[gi] = OP_LOAD;
                end else if (CELL_IDX < cnt_w) begin
                    cell_op[gi] = OP_FROM_PREV;
                end
            end
        end

        psst_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[gi]),
            .i_load  (load_data),
            .i_prev  (prev_val),
            .i_next  (next_val),
            .o_value (cell_val[gi])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_cmd_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !i_cmd.ready)
        else $error("command port ready during a read");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last_k) |=> (r_state == S_IDLE) && o_res.valid && o_res.last)
        else $error("read did not end on its last word");

    a_count_stable_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_count == $past(r_count)))
        else $error("entry count changed during a read");

endmodule
